// File: design/bpe_pkg.sv
package bpe_pkg;

  localparam int MAX_TOKENS    = 64;
  localparam int MERGE_ENTRIES = 4096;
  localparam int TOKEN_BITS    = 18;
  localparam int RANK_BITS     = 20;
  localparam int INDEX_BITS    = 12;
  localparam int IDX_W         = $clog2(MERGE_ENTRIES);
  localparam int POS_W         = $clog2(MAX_TOKENS);
  localparam int CNT_W         = $clog2(MAX_TOKENS + 1);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_TOKEN = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [INDEX_BITS-1:0] entry_index;
    logic                  entry_enable;
    logic [TOKEN_BITS-1:0] left_token;
    logic [TOKEN_BITS-1:0] right_token;
    logic [RANK_BITS-1:0]  merge_rank;
    logic [TOKEN_BITS-1:0] merged_token;
    logic [TOKEN_BITS-1:0] token;
    logic                  is_last;
  } in_item_t;

  typedef struct packed {
    logic [TOKEN_BITS-1:0] out_token;
    logic                  out_last;
    logic                  overflow;
  } out_item_t;

  // merge table entry
  typedef struct packed {
    logic                  valid;
    logic [TOKEN_BITS-1:0] left;
    logic [TOKEN_BITS-1:0] right;
    logic [RANK_BITS-1:0]  rank;
    logic [TOKEN_BITS-1:0] merged;
  } tbl_entry_t;

  // sequence entry: token and lookup result of the pair starting here
  typedef struct packed {
    logic [TOKEN_BITS-1:0] tok;
    logic                  hit;
    logic [RANK_BITS-1:0]  rank;
    logic [TOKEN_BITS-1:0] merged;
  } seq_entry_t;

  typedef struct packed {
    logic                  start;
    logic [TOKEN_BITS-1:0] left;
    logic [TOKEN_BITS-1:0] right;
  } lkup_req_t;

  typedef struct packed {
    logic                  ready;
    logic                  done;
    logic                  hit;
    logic [RANK_BITS-1:0]  rank;
    logic [TOKEN_BITS-1:0] merged;
  } lkup_rsp_t;

endpackage

// File: design/bpe_merge_engine.sv
// Table load and token append are taken only while the engine is idle.
// Merge: each pair lookup scans all 4096 table slots; the initial pass looks up
// every adjacent pair, and each merge costs a minimum search, a shift and up to
// two lookups; output holds each token until it is taken before reading the next.
// Reset (rst_n low, synchronous) empties the sequence and starts a clearing pass
// over all 4096 merge table slots; no item is accepted until it completes.
module bpe_merge_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bpe_pkg::out_item_t out_data
);
  import bpe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LK_A, S_LK_B, S_LK_C, S_LK_W,
    S_F_RD, S_F_CHK, S_F_END, S_MERGE, S_SH_RD, S_SH_WR, S_POSTM,
    S_O_RD, S_O_LD, S_O_WAIT
  } st_t;

  typedef enum logic [1:0] {C_INIT, C_POSTL, C_POSTR} ctx_t;

  st_t                   st_r;
  ctx_t                  ctx_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  drop_r;
  logic [POS_W-1:0]      p_r;
  logic [POS_W-1:0]      i_r;
  logic [POS_W-1:0]      best_r;
  logic                  any_r;
  logic [RANK_BITS-1:0]  best_rank_r;
  logic [TOKEN_BITS-1:0] best_tok_r;
  logic [TOKEN_BITS-1:0] tok_a_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic                  accept;
  logic                  seq_we;
  logic [POS_W-1:0]      seq_waddr;
  seq_entry_t            seq_wdata;
  logic [POS_W-1:0]      seq_raddr;
  seq_entry_t            seq_rdata;
  logic                  tbl_we;
  tbl_entry_t            tbl_wdata;
  lkup_req_t             lk_req;
  lkup_rsp_t             lk_rsp;
  logic [CNT_W-1:0]      n_app;
  logic [CNT_W-1:0]      n_dec;

  assign in_stall  = !(st_r == S_IDLE && lk_rsp.ready);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // length after appending the current token, and after one merge
  assign n_app = cnt_r + CNT_W'(cnt_r < CNT_W'(MAX_TOKENS));
  assign n_dec = cnt_r - 1'b1;

  // table load port
  always_comb begin
    tbl_we           = accept && in_data.req_type == REQ_LOAD;
    tbl_wdata.valid  = in_data.entry_enable;
    tbl_wdata.left   = in_data.left_token;
    tbl_wdata.right  = in_data.right_token;
    tbl_wdata.rank   = in_data.merge_rank;
    tbl_wdata.merged = in_data.merged_token;
  end

  bpe_lookup u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_we),
    .wr_idx   (in_data.entry_index[IDX_W-1:0]),
    .wr_entry (tbl_wdata),
    .req      (lk_req),
    .rsp      (lk_rsp)
  );

  always_comb begin
    lk_req.start = (st_r == S_LK_C);
    lk_req.left  = tok_a_r;
    lk_req.right = seq_rdata.tok;
  end

  // sequence memory access per state
  always_comb begin
    seq_we    = 1'b0;
    seq_waddr = p_r;
    seq_wdata = seq_rdata;
    seq_raddr = p_r;
    unique case (st_r)
      S_IDLE: begin
        seq_we        = accept && in_data.req_type == REQ_TOKEN &&
                        cnt_r < CNT_W'(MAX_TOKENS);
        seq_waddr     = cnt_r[POS_W-1:0];
        seq_wdata     = '0;
        seq_wdata.tok = in_data.token;
      end
      S_LK_A: seq_raddr = p_r;
      S_LK_B: seq_raddr = p_r + 1'b1;
      S_LK_W: begin
        seq_we           = lk_rsp.done;
        seq_waddr        = p_r;
        seq_wdata.tok    = tok_a_r;
        seq_wdata.hit    = lk_rsp.hit;
        seq_wdata.rank   = lk_rsp.rank;
        seq_wdata.merged = lk_rsp.merged;
      end
      S_F_RD:  seq_raddr = i_r;
      S_MERGE: begin
        seq_we        = 1'b1;
        seq_waddr     = best_r;
        seq_wdata     = '0;
        seq_wdata.tok = best_tok_r;
      end
      S_SH_RD: seq_raddr = i_r + 1'b1;
      S_SH_WR: begin
        seq_we    = 1'b1;
        seq_waddr = i_r;
      end
      S_O_RD: seq_raddr = i_r;
      default: ;
    endcase
  end

  bpe_ram #(.WIDTH($bits(seq_entry_t)), .DEPTH(MAX_TOKENS)) u_seq (
    .clk   (clk),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .raddr (seq_raddr),
    .rdata (seq_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ctx_r       <= C_INIT;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      p_r         <= '0;
      i_r         <= '0;
      any_r       <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (accept && in_data.req_type == REQ_TOKEN) begin
            cnt_r <= n_app;
            if (cnt_r == CNT_W'(MAX_TOKENS)) begin
              drop_r <= 1'b1;
            end
            if (in_data.is_last) begin
              p_r   <= '0;
              i_r   <= '0;
              ctx_r <= C_INIT;
              st_r  <= (n_app >= CNT_W'(2)) ? S_LK_A : S_O_RD;
            end
          end
        end
        S_LK_A: st_r <= S_LK_B;
        S_LK_B: begin
          tok_a_r <= seq_rdata.tok;
          st_r    <= S_LK_C;
        end
        S_LK_C: st_r <= S_LK_W;
        S_LK_W: begin
          if (lk_rsp.done) begin
            i_r   <= '0;
            any_r <= 1'b0;
            unique case (ctx_r)
              C_INIT: begin
                if (CNT_W'(p_r) + CNT_W'(2) < cnt_r) begin
                  p_r  <= p_r + 1'b1;
                  st_r <= S_LK_A;
                end else begin
                  st_r <= S_F_RD;
                end
              end
              C_POSTL: begin
                if (CNT_W'(best_r) + 1'b1 < cnt_r) begin
                  p_r   <= best_r;
                  ctx_r <= C_POSTR;
                  st_r  <= S_LK_A;
                end else begin
                  st_r <= S_F_RD;
                end
              end
              C_POSTR: st_r <= S_F_RD;
              default: st_r <= S_F_RD;
            endcase
          end
        end
        // lowest ranked hit, leftmost on ties
        S_F_RD: st_r <= S_F_CHK;
        S_F_CHK: begin
          if (seq_rdata.hit && (!any_r || seq_rdata.rank < best_rank_r)) begin
            any_r       <= 1'b1;
            best_r      <= i_r;
            best_rank_r <= seq_rdata.rank;
            best_tok_r  <= seq_rdata.merged;
          end
          if (CNT_W'(i_r) + CNT_W'(2) >= cnt_r) begin
            st_r <= S_F_END;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_F_RD;
          end
        end
        S_F_END: begin
          i_r  <= any_r ? best_r + 1'b1 : '0;
          st_r <= any_r ? S_MERGE : S_O_RD;
        end
        S_MERGE: begin
          st_r <= (CNT_W'(best_r) + CNT_W'(3) <= cnt_r) ? S_SH_RD : S_POSTM;
        end
        // close the gap one entry at a time
        S_SH_RD: st_r <= S_SH_WR;
        S_SH_WR: begin
          if (CNT_W'(i_r) + CNT_W'(2) >= cnt_r) begin
            st_r <= S_POSTM;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_SH_RD;
          end
        end
        S_POSTM: begin
          cnt_r <= n_dec;
          i_r   <= '0;
          any_r <= 1'b0;
          if (best_r != '0) begin
            p_r   <= best_r - 1'b1;
            ctx_r <= C_POSTL;
            st_r  <= S_LK_A;
          end else if (CNT_W'(best_r) + 1'b1 < n_dec) begin
            p_r   <= best_r;
            ctx_r <= C_POSTR;
            st_r  <= S_LK_A;
          end else begin
            st_r <= S_F_RD;
          end
        end
        // emit the sequence
        S_O_RD: st_r <= S_O_LD;
        S_O_LD: begin
          out_r.out_token <= seq_rdata.tok;
          out_r.out_last  <= (CNT_W'(i_r) + 1'b1 == cnt_r);
          out_r.overflow  <= drop_r;
          out_valid_r     <= 1'b1;
          st_r            <= S_O_WAIT;
        end
        S_O_WAIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_r.out_last) begin
              cnt_r  <= '0;
              drop_r <= 1'b0;
              st_r   <= S_IDLE;
            end else begin
              i_r  <= i_r + 1'b1;
              st_r <= S_O_RD;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/bpe_ram.sv
module bpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bpe_lookup.sv
module bpe_lookup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bpe_pkg::IDX_W-1:0]      wr_idx,
  input  bpe_pkg::tbl_entry_t            wr_entry,
  input  bpe_pkg::lkup_req_t             req,
  output bpe_pkg::lkup_rsp_t             rsp
);
  import bpe_pkg::*;

  typedef enum logic [1:0] {L_CLEAR, L_IDLE, L_SCAN} lst_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MERGE_ENTRIES - 1);

  lst_t                  st_r;
  logic [IDX_W-1:0]      addr_r;
  logic                  iss_done_r;
  logic                  cmp_vld_r;
  logic                  cmp_last_r;
  logic                  done_r;
  logic                  found_r;
  logic [TOKEN_BITS-1:0] key_l_r;
  logic [TOKEN_BITS-1:0] key_r_r;
  logic [RANK_BITS-1:0]  rank_r;
  logic [TOKEN_BITS-1:0] merged_r;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  tbl_entry_t            ram_wdata;
  tbl_entry_t            ram_rdata;
  logic                  better;

  // clearing pass owns the write port after reset
  always_comb begin
    ram_we    = (st_r == L_CLEAR) | wr_en;
    ram_waddr = (st_r == L_CLEAR) ? addr_r : wr_idx;
    ram_wdata = (st_r == L_CLEAR) ? '0 : wr_entry;
  end

  bpe_ram #(.WIDTH($bits(tbl_entry_t)), .DEPTH(MERGE_ENTRIES)) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // strict less keeps the lowest slot on equal ranks
  assign better = ram_rdata.valid && ram_rdata.left == key_l_r &&
                  ram_rdata.right == key_r_r &&
                  (!found_r || ram_rdata.rank < rank_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= L_CLEAR;
      addr_r     <= '0;
      iss_done_r <= 1'b0;
      cmp_vld_r  <= 1'b0;
      cmp_last_r <= 1'b0;
      done_r     <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      done_r    <= 1'b0;
      cmp_vld_r <= 1'b0;
      unique case (st_r)
        L_CLEAR: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == LAST_IDX) begin
            addr_r <= '0;
            st_r   <= L_IDLE;
          end
        end
        L_IDLE: begin
          if (req.start) begin
            key_l_r    <= req.left;
            key_r_r    <= req.right;
            found_r    <= 1'b0;
            addr_r     <= '0;
            iss_done_r <= 1'b0;
            st_r       <= L_SCAN;
          end
        end
        L_SCAN: begin
          // issue one slot per cycle, compare it in the cycle after
          if (!iss_done_r) begin
            cmp_vld_r  <= 1'b1;
            cmp_last_r <= (addr_r == LAST_IDX);
            addr_r     <= addr_r + 1'b1;
            if (addr_r == LAST_IDX) begin
              iss_done_r <= 1'b1;
            end
          end
          if (cmp_vld_r) begin
            if (better) begin
              found_r  <= 1'b1;
              rank_r   <= ram_rdata.rank;
              merged_r <= ram_rdata.merged;
            end
            if (cmp_last_r) begin
              done_r <= 1'b1;
              addr_r <= '0;
              st_r   <= L_IDLE;
            end
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.ready  = (st_r == L_IDLE);
    rsp.done   = done_r;
    rsp.hit    = found_r;
    rsp.rank   = rank_r;
    rsp.merged = merged_r;
  end

endmodule

// File: design/bpe_checker.sv
module bpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bpe_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no input taken while results are pending
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during output");

  // after a non-final result transfer the engine stays busy
  a_mid_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.out_last |=> in_stall)
    else $error("engine idle in mid sequence");

  // reset drops any result
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bpe_merge_engine bpe_checker u_bpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
